// File: src/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Types, mode codes, token kinds and character tables of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int unsigned CounterWidthDef = 16;
  localparam int unsigned OffsetWidthDef  = 24;
  localparam logic [30:0] ValMax = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_ZERO, M_DEC, M_PFX, M_RADIX, M_OP, M_LINE, M_BLK, M_BLKSTAR
  } mode_t;

  typedef enum logic [1:0] {RAD_DEC, RAD_HEX, RAD_BIN, RAD_OCT} radix_t;

  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_NUMBER = 6'd2;
  localparam logic [5:0] K_KW_BASE = 6'd3;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_OPEN_COMMENT = 3'd1;
  localparam logic [2:0] E_RANGE = 3'd5;
  localparam logic [2:0] E_LEAD_ZERO = 3'd6;
  localparam logic [2:0] E_BAD_CHAR = 3'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] num_value;
    logic        overflow;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    logic [5:0] k;
    k = K_END;
    unique case (p)
      "+": k = 6'd14;
      "-": k = 6'd16;
      "*": k = 6'd18;
      "/": k = 6'd19;
      "%": k = 6'd20;
      "(": k = 6'd21;
      ")": k = 6'd22;
      "{": k = 6'd23;
      "}": k = 6'd24;
      ";": k = 6'd25;
      "^": k = 6'd26;
      "&": k = 6'd27;
      "|": k = 6'd29;
      "~": k = 6'd31;
      "=": k = 6'd32;
      "<": k = 6'd34;
      ">": k = 6'd37;
      "!": k = 6'd40;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = K_END;
    priority if (p == "+" && c == "+") k = 6'd15;
    else if (p == "-" && c == "-") k = 6'd17;
    else if (p == "&" && c == "&") k = 6'd28;
    else if (p == "|" && c == "|") k = 6'd30;
    else if (p == "=" && c == "=") k = 6'd33;
    else if (p == "<" && c == "=") k = 6'd35;
    else if (p == "<" && c == "<") k = 6'd36;
    else if (p == ">" && c == "=") k = 6'd38;
    else if (p == ">" && c == ">") k = 6'd39;
    else if (p == "!" && c == "=") k = 6'd41;
    else k = K_END;
    return k;
  endfunction

  // Digit value in bits [3:0], valid flag in bit 4.
  function automatic logic [4:0] radix_digit(input radix_t r, input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    unique case (r)
      RAD_HEX: begin
        if (is_digit(c)) d = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f") d = {1'b1, 4'(c - 8'd87)};
        else if (c >= "A" && c <= "F") d = {1'b1, 4'(c - 8'd55)};
      end
      RAD_BIN: if (c == "0" || c == "1") d = {1'b1, 4'(c - 8'h30)};
      RAD_OCT: if (c >= "0" && c <= "7") d = {1'b1, 4'(c - 8'h30)};
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Keyword bytes packed with the first character in the low byte, and lengths.
  localparam logic [63:0] KwText [11] = '{
    64'h0000_0000_0074_656C,        // let
    64'h0000_0000_0000_6669,        // if
    64'h0000_0000_6573_6C65,        // else
    64'h0000_0065_6C69_6877,        // while
    64'h0000_0000_0072_6F66,        // for
    64'h0000_006B_6165_7262,        // break
    64'h6575_6E69_746E_6F63,        // continue
    64'h0000_0074_6E69_7270,        // print
    64'h0000_0074_7570_6E69,        // input
    64'h0000_0000_6575_7274,        // true
    64'h0000_0065_736C_6166         // false
  };
  localparam logic [3:0] KwLen [11] = '{
    4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd5, 4'd5, 4'd4, 4'd5
  };

endpackage

// File: src/stok_core.sv
// ----------------------------------------------------------------------------
// stok_core
// Lexer state and single-pass next-state logic for one input transfer.
// ----------------------------------------------------------------------------
module stok_core #(
  parameter int unsigned COUNTER_WIDTH = stok_pkg::CounterWidthDef,
  parameter int unsigned OFFSET_WIDTH  = stok_pkg::OffsetWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  stok_pkg::in_item_t  item,
  output logic [1:0]          res_count,
  output stok_pkg::out_item_t res0,
  output stok_pkg::out_item_t res1
);
  import stok_pkg::*;

  localparam logic [COUNTER_WIDTH-1:0] CntMax = '1;
  localparam logic [OFFSET_WIDTH-1:0]  OffMax = '1;
  localparam logic [COUNTER_WIDTH-1:0] CntOne = COUNTER_WIDTH'(1);

  mode_t                    mode_r, mode_nxt;
  logic [COUNTER_WIDTH-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [OFFSET_WIDTH-1:0]  off_r, off_nxt;
  logic [COUNTER_WIDTH-1:0] sline_r, sline_nxt, scol_r, scol_nxt;
  logic [OFFSET_WIDTH-1:0]  soff_r, soff_nxt;
  logic [15:0]              len_r, len_nxt;
  logic [30:0]              acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  radix_t                   rad_r, rad_nxt;
  logic [63:0]              kwb_r, kwb_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic                     halt_r, halt_nxt;

  logic [7:0]  c;
  logic [4:0]  rd;
  logic [34:0] dec_v;
  logic [34:0] rad_v;
  logic [5:0]  id_kind;
  logic        do_idle;
  logic [1:0]  n;
  out_item_t   r0, r1, rr;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [23:0] sat24(input logic [31:0] v);
    return (v > 32'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  always_comb begin
    id_kind = K_IDENT;
    for (int k = 0; k < 11; k++) begin
      if (len_r == 16'(KwLen[k]) && kwb_r == KwText[k]) id_kind = K_KW_BASE + 6'(k);
    end
  end

  always_comb begin
    c = item.ch;
    rd = radix_digit(rad_r, c);
    dec_v = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + 35'(c - 8'h30);
    unique case (rad_r)
      RAD_HEX: rad_v = {acc_r, 4'b0} | 35'(rd[3:0]);
      RAD_BIN: rad_v = {3'b0, acc_r, 1'b0} | 35'(rd[3:0]);
      default: rad_v = {1'b0, acc_r, 3'b0} | 35'(rd[3:0]);
    endcase
  end

  always_comb begin
    mode_t m;
    logic [COUNTER_WIDTH-1:0] ln, cl, sl, sc;
    logic [OFFSET_WIDTH-1:0]  of, so;
    logic [15:0] ln16;
    logic [30:0] ac;
    logic ov, ht, fin;
    radix_t rs;
    logic [63:0] kb;
    logic [7:0] pc;
    m = mode_r; ln = line_r; cl = col_r; of = off_r; sl = sline_r; sc = scol_r;
    so = soff_r; ln16 = len_r; ac = acc_r; ov = ovf_r; rs = rad_r; kb = kwb_r;
    pc = pend_r; ht = halt_r;
    n = 2'd0; r0 = '0; r1 = '0; do_idle = 1'b0; fin = 1'b0;
    rr = '0;

    if (item.action) begin
      if (!halt_r) fin = 1'b1;
    end else if (!halt_r) begin
      unique case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            for (int i = 0; i < 8; i++) if (len_r == 16'(i)) kb[8*i +: 8] = c;
            ln16 = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            fin = 1'b1; do_idle = 1'b1;
          end
        end
        M_ZERO: begin
          if (c == "x" || c == "X" || c == "b" || c == "B" || c == "o" || c == "O") begin
            rs = (c == "x" || c == "X") ? RAD_HEX : (c == "b" || c == "B") ? RAD_BIN : RAD_OCT;
            m = M_PFX;
            ln16 = len_r + 16'd1;
          end else if (c >= "1" && c <= "9") begin
            rr.kind = K_END; rr.error_code = E_LEAD_ZERO;
            rr.start_line = sat16(32'(sline_r)); rr.start_column = sat16(32'(scol_r));
            rr.start_offset = sat24(32'(soff_r));
            r0 = rr; n = 2'd1; ht = 1'b1; m = M_IDLE;
          end else if (c == "0") begin
            ac = '0; m = M_DEC; ln16 = len_r + 16'd1;
          end else begin
            fin = 1'b1; do_idle = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(c)) begin
            if (dec_v > 35'(ValMax)) begin ac = ValMax; ov = 1'b1; end
            else ac = dec_v[30:0];
            ln16 = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            fin = 1'b1; do_idle = 1'b1;
          end
        end
        M_PFX: begin
          if (rd[4]) begin
            ac = 31'(rd[3:0]); m = M_RADIX; ln16 = len_r + 16'd1;
          end else fin = 1'b1;
        end
        M_RADIX: begin
          if (rd[4]) begin
            if (!ovf_r) begin
              if (rad_v > 35'(ValMax)) ov = 1'b1;
              else ac = rad_v[30:0];
            end
            ln16 = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            fin = 1'b1; do_idle = 1'b1;
          end
        end
        M_OP: begin
          if (pend_r == "/" && (c == "/" || c == "*")) begin
            m = (c == "/") ? M_LINE : M_BLK;
          end else if (pair_kind(pend_r, c) != K_END) begin
            ln16 = len_r + 16'd1;
            rr.kind = pair_kind(pend_r, c);
            rr.start_line = sat16(32'(sline_r)); rr.start_column = sat16(32'(scol_r));
            rr.start_offset = sat24(32'(soff_r)); rr.token_length = ln16;
            r0 = rr; n = 2'd1; m = M_IDLE;
          end else begin
            fin = 1'b1; do_idle = 1'b1;
          end
        end
        M_LINE: if (c == 8'h0A) m = M_IDLE;
        M_BLK: if (c == "*") m = M_BLKSTAR;
        M_BLKSTAR: begin
          if (c == "/") m = M_IDLE;
          else if (c != "*") m = M_BLK;
        end
        default: do_idle = 1'b1;
      endcase
    end

    // Close the pending token at the current position.
    if (fin) begin
      rr = '0;
      rr.start_line = sat16(32'(sline_r)); rr.start_column = sat16(32'(scol_r));
      rr.start_offset = sat24(32'(soff_r)); rr.token_length = len_r;
      unique case (mode_r)
        M_IDENT: rr.kind = id_kind;
        M_ZERO: rr.kind = K_NUMBER;
        M_DEC: begin rr.kind = K_NUMBER; rr.num_value = acc_r; rr.overflow = ovf_r; end
        M_OP: rr.kind = single_kind(pend_r);
        M_RADIX: begin
          rr.kind = K_NUMBER; rr.num_value = acc_r;
          if (ovf_r) begin
            rr = '0; rr.error_code = E_RANGE;
            rr.start_line = sat16(32'(line_r)); rr.start_column = sat16(32'(col_r));
            rr.start_offset = sat24(32'(off_r)); ht = 1'b1;
          end
        end
        M_PFX: begin
          rr = '0; rr.error_code = 3'(rad_r) + 3'd1;
          rr.start_line = sat16(32'(line_r)); rr.start_column = sat16(32'(col_r));
          rr.start_offset = sat24(32'(off_r)); ht = 1'b1;
        end
        M_BLK, M_BLKSTAR: begin
          rr = '0; rr.error_code = E_OPEN_COMMENT;
          rr.start_line = sat16(32'(sline_r)); rr.start_column = sat16(32'(col_r));
          rr.start_offset = sat24(32'(off_r)); ht = 1'b1;
        end
        default: rr = '0;
      endcase
      if (mode_r != M_IDLE && mode_r != M_LINE) begin r0 = rr; n = 2'd1; end
      m = M_IDLE;
      if (ht) do_idle = 1'b0;
    end

    // Advance the position for every byte that is consumed; hold it on a halt.
    if (!item.action && !halt_r) begin
      if (c == 8'h0A) begin
        ln = (line_r == CntMax) ? line_r : line_r + CntOne;
        cl = CntOne;
      end else cl = (col_r == CntMax) ? col_r : col_r + CntOne;
      of = (off_r == OffMax) ? off_r : off_r + OFFSET_WIDTH'(1);
      if (ht) begin
        ln = line_r; cl = col_r; of = off_r;
      end
    end

    if (do_idle) begin
      if (!(c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A)) begin
        sl = line_r; sc = col_r; so = off_r; ln16 = 16'd1; ac = '0; ov = 1'b0; kb = '0;
        rr = '0;
        if (is_alpha(c) || c == "_") begin
          kb = 64'(c); m = M_IDENT;
        end else if (c == "0") begin
          rs = RAD_DEC; m = M_ZERO;
        end else if (is_digit(c)) begin
          ac = 31'(c - 8'h30); rs = RAD_DEC; m = M_DEC;
        end else if (pair_kind(c, "=") != K_END || pair_kind(c, c) != K_END || c == "/") begin
          pc = c; m = M_OP;
        end else if (single_kind(c) != K_END) begin
          rr.kind = single_kind(c);
          rr.start_line = sat16(32'(line_r)); rr.start_column = sat16(32'(col_r));
          rr.start_offset = sat24(32'(off_r)); rr.token_length = 16'd1;
          m = M_IDLE;
        end else begin
          ln16 = 16'd0;
          rr.error_code = E_BAD_CHAR;
          rr.start_line = sat16(32'(ln)); rr.start_column = sat16(32'(cl));
          rr.start_offset = sat24(32'(of));
          ht = 1'b1; m = M_IDLE;
        end
        if (rr.kind != K_END || rr.error_code != E_NONE) begin
          if (n == 2'd0) r0 = rr; else r1 = rr;
          n = n + 2'd1;
        end
      end
    end

    if (item.action) begin
      rr = '0;
      rr.start_line = sat16(32'(line_r)); rr.start_column = sat16(32'(col_r));
      rr.start_offset = sat24(32'(off_r));
      if (n == 2'd0) r0 = rr; else r1 = rr;
      n = n + 2'd1;
      m = M_IDLE; ln = CntOne; cl = CntOne; of = '0; sl = CntOne; sc = CntOne; so = '0;
      ln16 = '0; ac = '0; ov = 1'b0; rs = RAD_DEC; kb = '0; pc = '0; ht = 1'b0;
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    mode_nxt = m; line_nxt = ln; col_nxt = cl; off_nxt = of; sline_nxt = sl;
    scol_nxt = sc; soff_nxt = so; len_nxt = ln16; acc_nxt = ac; ovf_nxt = ov;
    rad_nxt = rs; kwb_nxt = kb; pend_nxt = pc; halt_nxt = ht;
  end

  assign res_count = step ? n : 2'd0;
  assign res0 = r0;
  assign res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; line_r <= CntOne; col_r <= CntOne; off_r <= '0;
      sline_r <= CntOne; scol_r <= CntOne; soff_r <= '0; len_r <= '0;
      acc_r <= '0; ovf_r <= 1'b0; rad_r <= RAD_DEC; kwb_r <= '0; pend_r <= '0;
      halt_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt;
      sline_r <= sline_nxt; scol_r <= scol_nxt; soff_r <= soff_nxt; len_r <= len_nxt;
      acc_r <= acc_nxt; ovf_r <= ovf_nxt; rad_r <= rad_nxt; kwb_r <= kwb_nxt;
      pend_r <= pend_nxt; halt_r <= halt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_count != 2'd3)
    else $error("more than two results");
  assert property (@(posedge clk) disable iff (!rst_n) halt_r |-> mode_r == M_IDLE)
    else $error("halted outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.action) |=> (mode_r == M_IDLE && !halt_r && off_r == '0))
    else $error("end marker did not clear state");
endmodule

// File: src/source_tokenizer_unit.sv
// A result is written into the registered result queue by the input transfer that makes it.
// Throughput: one input byte per cycle while the four-entry result queue holds two
// or fewer results; in_ready drops at three or more, since one byte makes up to two.
// Reset (rst_n low, synchronous) returns the lexer to line 1, column 1, offset 0
// and empties the queue.
// ----------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming tokenizer top level with an output result queue.
// ----------------------------------------------------------------------------
module source_tokenizer_unit #(
  parameter int unsigned COUNTER_WIDTH = stok_pkg::CounterWidthDef,
  parameter int unsigned OFFSET_WIDTH  = stok_pkg::OffsetWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stok_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stok_pkg::out_item_t out_data
);
  import stok_pkg::*;

  out_item_t  q_r [4];
  logic [1:0] rp_r, wp_r;
  logic [2:0] cnt_r;
  logic [1:0] nres;
  out_item_t  r0, r1;
  logic       step, pop;

  // Accept only with room for two results.
  assign in_ready = (cnt_r <= 3'd2);
  assign step = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data = q_r[rp_r];
  assign pop = out_valid && out_ready;

  stok_core #(.COUNTER_WIDTH(COUNTER_WIDTH), .OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_data),
    .res_count(nres), .res0(r0), .res1(r1)
  );

  always_ff @(posedge clk) begin
    if (nres != 2'd0) q_r[wp_r] <= r0;
    if (nres == 2'd2) q_r[wp_r + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0; wp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + nres;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(nres) - 3'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) (step && in_data.action) |-> nres != 2'd0)
    else $error("end marker gave no result");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> cnt_r != 3'd0)
    else $error("valid on empty queue");
endmodule
